>>> src/fsmf_pkg.sv
// Package for the first substring match finder.
// Holds default sizes, configuration register codes, shared types and helpers.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps

package fsmf_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int              MAX_PATTERN_DEF = 16;
  localparam longint unsigned MAX_TEXT_DEF    = 64'd65536;

  // Fixed field widths
  localparam int PATTERN_W   = 128;  // sixteen pattern bytes
  localparam int PLEN_W      = 5;
  localparam int POSITION_W  = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 8'd0,
    REG_PATTERN_HIGH = 8'd1,
    REG_PATTERN_LEN  = 8'd2,
    REG_SEARCH_START = 8'd3
  } cfg_reg_t;

  // Register contents seen by the datapath
  typedef struct packed {
    logic [PATTERN_W-1:0]  pattern;
    logic [PLEN_W-1:0]     pattern_length;
    logic [POSITION_W-1:0] search_start;
  } cfg_t;

  // Window control from the search stage
  typedef struct packed {
    logic step;   // shift in the byte held in the input register
    logic clear;  // end of text: empty the window
  } win_ctrl_t;

  // Byte i of the pattern, byte 0 in bits 7..0
  function automatic logic [7:0] pattern_byte(input logic [PATTERN_W-1:0] pat,
                                              input logic [3:0] idx);
    return pat[{idx, 3'b000} +: 8];
  endfunction

endpackage

>>> src/fsmf_text_if.sv
// Text input channel of the first substring match finder.
// Depends on nothing; one transaction carries one text byte.
`timescale 1ns / 1ps

interface fsmf_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> src/fsmf_result_if.sv
// Result channel of the first substring match finder.
// Depends on fsmf_pkg for the position width.
`timescale 1ns / 1ps

interface fsmf_result_if;
  logic                              valid;
  logic                              ready;
  logic                              match_found;
  logic [fsmf_pkg::POSITION_W-1:0]   match_position;

  modport source (output valid, output match_found, output match_position, input ready);
  modport sink   (input valid, input match_found, input match_position, output ready);
endinterface

>>> src/fsmf_cfg_if.sv
// Configuration write channel of the first substring match finder.
// Depends on fsmf_pkg for index and data widths.
`timescale 1ns / 1ps

interface fsmf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fsmf_pkg::CFG_INDEX_W-1:0] index;
  logic [fsmf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/first_substring_match_finder.sv
// Top level of the first substring match finder.
// Depends on fsmf_pkg, the three channel interfaces, fsmf_cfg_regs and fsmf_window_match.
`timescale 1ns / 1ps

// Takes one text byte per clock and finds the first position at or after
// search_start where the pattern (1 to 16 bytes, pattern_length) begins.
// Each byte lands in an input register; from there the search stage shifts
// it into the window, compares the window with the pattern and updates
// the byte count and the first-hit latch. The byte marked end_of_text
// loads one result from the input register into the output register, and the
// window, count and latch then start over for the next text. Throughput is
// one byte per cycle; the input stalls only while a finished result waits
// in the output register and the next end-of-text byte needs it. Positions
// at or past MAX_TEXT take no part in matching, and match starts above
// 65535 are never reported. Configuration writes are taken every cycle and
// should only be issued while no text is in flight.
module first_substring_match_finder #(
  parameter int              MAX_PATTERN = fsmf_pkg::MAX_PATTERN_DEF,
  parameter longint unsigned MAX_TEXT    = fsmf_pkg::MAX_TEXT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  fsmf_text_if.sink       text_in,
  fsmf_result_if.source   result_out,
  fsmf_cfg_if.sink        cfg_wr
);
  import fsmf_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W = $clog2(MAX_TEXT + 1);
  localparam int POS_W = (CNT_W > POSITION_W + 1) ? CNT_W : POSITION_W + 1;

  cfg_t       regs;
  win_ctrl_t  win_ctrl;
  logic       win_match;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eot;

  // Per-text search state
  logic [CNT_W-1:0]      byte_count;
  logic                  hit_seen;
  logic [POSITION_W-1:0] hit_position;

  // Output register
  logic                  out_valid;
  logic                  out_found;
  logic [POSITION_W-1:0] out_position;

  logic                  stage_go;
  logic [LEN_W-1:0]      len_eff;
  logic                  count_live;
  logic [POS_W-1:0]      cand_end;
  logic [POS_W-1:0]      cand_begin;
  logic                  qualifies;

  fsmf_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .regs   (regs)
  );

  // Pattern length clamped to the window depth
  assign len_eff = (regs.pattern_length > PLEN_W'(MAX_PATTERN)) ?
                   LEN_W'(MAX_PATTERN) : regs.pattern_length[LEN_W-1:0];

  // Search stage advances unless an end-of-text byte finds the output full
  assign stage_go = in_valid && (!in_eot || !out_valid || result_out.ready);
  assign text_in.ready = !in_valid || stage_go;

  assign win_ctrl.step  = stage_go;
  assign win_ctrl.clear = in_eot;

  fsmf_window_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window_match (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (win_ctrl),
    .text_byte (in_byte),
    .pattern   (regs.pattern),
    .len_eff   (len_eff),
    .match     (win_match)
  );

  // Candidate start for the byte in the search stage
  assign count_live = (byte_count != CNT_W'(MAX_TEXT));
  assign cand_end   = POS_W'(byte_count) + POS_W'(1);
  assign cand_begin = cand_end - POS_W'(len_eff);
  assign qualifies  = count_live && !hit_seen && (len_eff != '0) &&
                      (cand_end >= POS_W'(len_eff)) &&
                      (cand_begin >= POS_W'(regs.search_start)) &&
                      (cand_begin <= POS_W'({POSITION_W{1'b1}})) &&
                      win_match;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text_in.ready) begin
      in_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      in_byte <= text_in.text_byte;
      in_eot  <= text_in.end_of_text;
    end
  end

  // Byte count and first-hit latch
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      hit_seen     <= 1'b0;
      hit_position <= '0;
    end else if (stage_go) begin
      if (in_eot) begin
        byte_count   <= '0;
        hit_seen     <= 1'b0;
        hit_position <= '0;
      end else begin
        if (count_live) byte_count <= byte_count + CNT_W'(1);
        if (qualifies) begin
          hit_seen     <= 1'b1;
          hit_position <= cand_begin[POSITION_W-1:0];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go && in_eot) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && in_eot) begin
      out_found    <= hit_seen || qualifies;
      out_position <= hit_seen  ? hit_position :
                      qualifies ? cand_begin[POSITION_W-1:0] : '0;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.match_found    = out_found;
  assign result_out.match_position = out_position;

  // An end-of-text byte always leaves a result behind
  a_eot_loads_result: assert property (@(posedge clk) disable iff (rst)
    (stage_go && in_eot) |=> out_valid)
    else $error("end-of-text byte did not produce a result");

  // A miss always reports position zero
  a_miss_position_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_position == '0))
    else $error("no-match result carries a nonzero position");

  // Count saturates at the text limit
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(MAX_TEXT))
    else $error("byte count ran past its limit");

  // Per-text state starts over after the end of a text
  a_text_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (stage_go && in_eot) |=> ((byte_count == '0) && !hit_seen))
    else $error("search state not cleared after end of text");

endmodule

>>> src/fsmf_cfg_regs.sv
// Configuration register file: pattern words, pattern length, search start.
// Depends on fsmf_pkg and fsmf_cfg_if.
`timescale 1ns / 1ps

module fsmf_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  fsmf_cfg_if.sink           cfg_wr,
  output fsmf_pkg::cfg_t     regs
);
  import fsmf_pkg::*;

  cfg_t regs_r;

  // Writes are taken every cycle
  assign cfg_wr.ready = 1'b1;
  assign regs         = regs_r;

  // Register write decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs_r.pattern        <= '0;
      regs_r.pattern_length <= PLEN_W'(1);
      regs_r.search_start   <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_PATTERN_LOW:  regs_r.pattern[63:0]    <= cfg_wr.data;
        REG_PATTERN_HIGH: regs_r.pattern[127:64]  <= cfg_wr.data;
        REG_PATTERN_LEN:  regs_r.pattern_length   <= cfg_wr.data[PLEN_W-1:0];
        REG_SEARCH_START: regs_r.search_start     <= cfg_wr.data[POSITION_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/fsmf_window_match.sv
// Sliding byte window and pattern comparator.
// Flags whether the window, with the incoming byte shifted in, ends in the pattern.
// Depends on fsmf_pkg.
`timescale 1ns / 1ps

module fsmf_window_match #(
  parameter int  MAX_PATTERN = fsmf_pkg::MAX_PATTERN_DEF,
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fsmf_pkg::win_ctrl_t           ctrl,
  input  logic [7:0]                    text_byte,
  input  logic [fsmf_pkg::PATTERN_W-1:0] pattern,
  input  logic [LEN_W-1:0]              len_eff,
  output logic                          match
);
  import fsmf_pkg::*;

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [7:0]       window      [MAX_PATTERN];
  logic [7:0]       window_next [MAX_PATTERN];
  logic [LEN_W-1:0] lane_idx    [MAX_PATTERN];
  logic [7:0]       lane_byte   [MAX_PATTERN];
  logic             mismatch;

  // Window after the incoming byte; entry 0 is the newest byte
  always_comb begin
    window_next[0] = text_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_next[k] = window[k-1];
    end
  end

  // Pattern byte i lines up with window entry len-1-i
  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      lane_idx[i]  = len_eff - LEN_W'(i + 1);
      lane_byte[i] = window_next[lane_idx[i][IDX_W-1:0]];
      if ((LEN_W'(i) < len_eff) && (lane_byte[i] != pattern_byte(pattern, 4'(i)))) begin
        mismatch = 1'b1;
      end
    end
    match = (len_eff != '0) && !mismatch;
  end

  // Window shift, emptied at the end of each text
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PATTERN; k++) window[k] <= '0;
    end else if (ctrl.step) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window[k] <= ctrl.clear ? 8'h00 : window_next[k];
      end
    end
  end

endmodule
